// ===== sv/mtg_pkg.sv =====
package mtg_pkg;

   localparam int unsigned STATE_WORDS_DEFAULT  = 624;
   localparam int unsigned SHIFT_OFFSET_DEFAULT = 397;

   localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
   localparam logic [31:0] HIGH_BIT     = 32'h8000_0000;
   localparam logic [31:0] LOW_BITS     = 32'h7fff_ffff;
   localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
   localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
   localparam logic [31:0] SEED_MULT    = 32'd69069;
   localparam logic [31:0] MIX_START    = 32'd373737;
   localparam logic [31:0] MIX_MULT     = 32'd5531;
   localparam logic [31:0] MIX_ADD      = 32'd81547;

   // request kinds carried on req_tuser
   localparam logic OP_DRAW   = 1'b0;
   localparam logic OP_RESEED = 1'b1;

   // seeder to top: fill in progress and the word to shift in
   typedef struct packed {
      logic        busy;
      logic [31:0] fill_word;
   } seed_status_type;

   function automatic logic [31:0] twist_word(input logic [31:0] cur,
                                              input logic [31:0] nxt,
                                              input logic [31:0] far);
      logic [31:0] y;
      logic [31:0] v;
      y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
      v = far ^ (y >> 1);
      if (y[0]) begin
         v = v ^ TWIST_MATRIX;
      end
      return v;
   endfunction

   function automatic logic [31:0] temper_word(input logic [31:0] w);
      logic [31:0] y;
      y = w ^ (w >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

// ===== sv/mtg_cell.sv =====
module mtg_cell (
   input  logic        clock,
   input  logic        shift,
   input  logic [31:0] word_in,
   output logic [31:0] word_out
);

   logic [31:0] word_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         word_ff <= word_in;
      end
   end

   assign word_out = word_ff;

endmodule

// ===== sv/mtg_seed.sv =====
module mtg_seed #(
   parameter int unsigned STATE_WORDS = mtg_pkg::STATE_WORDS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [31:0]              seed,
   output mtg_pkg::seed_status_type status
);

   localparam int unsigned CountWidth = $clog2(STATE_WORDS);

   logic                  busy_ff;
   logic [CountWidth-1:0] count_ff;
   logic [31:0]           mult_ff;
   logic [31:0]           mult_in;
   logic [31:0]           mix_ff;
   logic [31:0]           mix_sum;
   logic [31:0]           mix_in;

   // product chain seed * 69069^k, and the mixing sequence
   assign mult_in = mult_ff * mtg_pkg::SEED_MULT;
   assign mix_sum = mix_ff * mtg_pkg::MIX_MULT + mtg_pkg::MIX_ADD;
   assign mix_in  = mix_sum ^ (mix_sum >> 9) ^ (mix_sum << 19);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else if (start) begin
         busy_ff  <= 1'b1;
         count_ff <= CountWidth'(1);
      end else if (busy_ff) begin
         count_ff <= count_ff + CountWidth'(1);
         if (count_ff == CountWidth'(STATE_WORDS - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mult_ff <= seed;
         mix_ff  <= mtg_pkg::MIX_START;
      end else if (busy_ff) begin
         mult_ff <= mult_in;
         mix_ff  <= mix_in;
      end
   end

   assign status.busy      = busy_ff;
   assign status.fill_word = mult_in ^ mix_ff;

endmodule

// ===== sv/mersenne_twister_generator_core.sv =====
// MT19937 pseudo-random word generator.
//
// Request channel (req_*): each item is a draw (req_tuser = 0) or a reseed
// (req_tuser = 1, seed in req_tdata). Result channel (rsp_*): one tempered
// 32-bit word per draw, read as an unsigned 0.32 fraction; reseeds give none.
//
// The state is a ring of 624 one-word cells that shifts toward cell 0. A draw
// twists cells 0, 1 and 397 into the next table word, returns it tempered and
// shifts it in at the tail, so regeneration is spread one word per draw.
// Draws sustain one item per cycle while the receiver keeps up and no fill
// is running; the result is registered.
// A reseed shifts in the seed word and then 623 seeded words, one per cycle,
// the seeded words coming from the seeder (two 32-bit multiplies per step);
// req_tready is low during the fill.
// When the receiver stalls, the result holds in the output register and
// req_tready drops until it is taken; a new item is accepted in the same cycle
// the waiting result leaves.
// Reset clears the control state only; the ring is undefined until the first
// reseed, and draws must not come before one.
module mersenne_twister_generator_core #(
   parameter int unsigned STATE_WORDS  = mtg_pkg::STATE_WORDS_DEFAULT,
   parameter int unsigned SHIFT_OFFSET = mtg_pkg::SHIFT_OFFSET_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] seed_value
   input  logic        req_tuser,   // [0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [31:0] random_word
);

   mtg_pkg::seed_status_type seed_status;

   logic [31:0] cell_word [STATE_WORDS];
   logic [31:0] tail_word;
   logic [31:0] twisted;
   logic        accept;
   logic        draw;
   logic        reseed;
   logic        shift;
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;

   assign req_tready = !seed_status.busy && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign draw       = accept && (req_tuser == mtg_pkg::OP_DRAW);
   assign reseed     = accept && (req_tuser == mtg_pkg::OP_RESEED);
   assign shift      = draw || reseed || seed_status.busy;

   // next table word from the head, its neighbor and the far tap
   assign twisted = mtg_pkg::twist_word(cell_word[0], cell_word[1],
                                        cell_word[SHIFT_OFFSET]);

   always_comb begin
      if (reseed) begin
         tail_word = req_tdata;
      end else if (seed_status.busy) begin
         tail_word = seed_status.fill_word;
      end else begin
         tail_word = twisted;
      end
   end

   mtg_seed #(
      .STATE_WORDS(STATE_WORDS)
   ) u_seed (
      .clock (clock),
      .reset (reset),
      .start (reseed),
      .seed  (req_tdata),
      .status(seed_status)
   );

   // ring of cells; cell 0 is the oldest word, the tail takes the new one
   for (genvar i = 0; i < STATE_WORDS; i++) begin : g_cell
      if (i == STATE_WORDS - 1) begin : g_tail
         mtg_cell u_cell (
            .clock   (clock),
            .shift   (shift),
            .word_in (tail_word),
            .word_out(cell_word[i])
         );
      end else begin : g_body
         mtg_cell u_cell (
            .clock   (clock),
            .shift   (shift),
            .word_in (cell_word[i+1]),
            .word_out(cell_word[i])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (draw) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (draw) begin
         rsp_data_ff <= mtg_pkg::temper_word(twisted);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== tb/sv/mt_stream_checker.sv =====
`timescale 1ns / 1ps

module mt_stream_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] seed_value
   input  logic        req_tuser,   // [0] operation
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // [31:0] random_word
   output int          fail_count,
   output int          words_pending,
   output int          words_checked
);

   localparam int RING_WORDS = mtg_pkg::STATE_WORDS_DEFAULT;
   localparam int FAR_OFFSET = mtg_pkg::SHIFT_OFFSET_DEFAULT;

   logic [31:0] mt_ring [RING_WORDS];
   int          ring_pos;
   logic [31:0] expected_words [$];
   logic [31:0] next_word;

   function automatic logic [31:0] tempered(input logic [31:0] w);
      logic [31:0] t;
      t = w ^ (w >> 11);
      t = t ^ ((t << 7) & mtg_pkg::TEMPER_B);
      t = t ^ ((t << 15) & mtg_pkg::TEMPER_C);
      t = t ^ (t >> 18);
      return t;
   endfunction

   // in-place twist; late cells see already-updated early cells
   task automatic twist_ring();
      logic [31:0] y;
      logic [31:0] v;
      for (int k = 0; k < RING_WORDS; k++) begin
         y = (mt_ring[k] & mtg_pkg::HIGH_BIT)
             | (mt_ring[(k + 1) % RING_WORDS] & mtg_pkg::LOW_BITS);
         v = mt_ring[(k + FAR_OFFSET) % RING_WORDS] ^ (y >> 1);
         if (y[0]) begin
            v = v ^ mtg_pkg::TWIST_MATRIX;
         end
         mt_ring[k] = v;
      end
   endtask

   task automatic seed_ring(input logic [31:0] seed);
      logic [31:0] s;
      s = mtg_pkg::MIX_START;
      mt_ring[0] = seed;
      for (int k = 1; k < RING_WORDS; k++) begin
         mt_ring[k] = mt_ring[k - 1] * mtg_pkg::SEED_MULT;
      end
      for (int k = 1; k < RING_WORDS; k++) begin
         mt_ring[k] = mt_ring[k] ^ s;
         s = s * mtg_pkg::MIX_MULT + mtg_pkg::MIX_ADD;
         s = s ^ (s >> 9) ^ (s << 19);
      end
      ring_pos = RING_WORDS;
   endtask

   initial begin
      fail_count    = 0;
      words_checked = 0;
      words_pending = 0;
      ring_pos      = RING_WORDS;
   end

   always @(posedge clock) begin
      if (reset) begin
         expected_words.delete();
         ring_pos = RING_WORDS;
      end else begin
         // results first: a word leaving now belongs to an earlier item
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               if (fail_count < 10) begin
                  $display("[%0t] unexpected word %08h", $realtime, rsp_tdata);
               end
               fail_count++;
            end else begin
               next_word = expected_words.pop_front();
               if (rsp_tdata !== next_word) begin
                  if (fail_count < 10) begin
                     $display("[%0t] random_word mismatch: expected %08h got %08h",
                              $realtime, next_word, rsp_tdata);
                  end
                  fail_count++;
               end
               words_checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == mtg_pkg::OP_RESEED) begin
               seed_ring(req_tdata);
            end else begin
               if (ring_pos >= RING_WORDS) begin
                  twist_ring();
                  ring_pos = 0;
               end
               expected_words.push_back(tempered(mt_ring[ring_pos]));
               ring_pos = ring_pos + 1;
            end
         end
      end
      words_pending = expected_words.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   // stimulus volume and pacing
   localparam int RANDOM_ITEMS = 2000;
   localparam int DRAIN_CYCLES = 20;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = 32'h0;            // [31:0] seed_value
   logic        req_tuser  = mtg_pkg::OP_DRAW; // [0] operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;                     // [31:0] random_word

   int fail_count;
   int words_pending;
   int words_checked;

   // pacing knobs, changed per stimulus block
   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;

   int reseeds_sent   = 0;
   int draws_sent     = 0;
   int blocks_run     = 0;

   mersenne_twister_generator_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   mt_stream_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .words_pending (words_pending),
      .words_checked (words_checked)
   );

   // 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Offer one item and hold it until the block takes it. Idle gaps come
   // before the item, so valid only drops between items, never mid-offer.
   task automatic send_item(input logic op, input logic [31:0] data);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      if (op == mtg_pkg::OP_RESEED) begin
         reseeds_sent++;
      end else begin
         draws_sent++;
      end
   endtask

   // draw payload is ignored by the block; random bits still toggle the bus
   task automatic send_draws(input int count);
      for (int i = 0; i < count; i++) begin
         send_item(mtg_pkg::OP_DRAW, $urandom());
      end
   endtask

   // four pacing modes: none, sender gaps, receiver stalls, both
   task automatic set_pacing(input int mode);
      case (mode)
         0: begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         1: begin
            send_idle_pct = 68;
            rsp_stall_pct = 0;
         end
         2: begin
            send_idle_pct = 0;
            rsp_stall_pct = 68;
         end
         default: begin
            send_idle_pct = 36;
            rsp_stall_pct = 36;
         end
      endcase
   endtask

   function automatic logic [31:0] pick_seed();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'hffff_ffff;
         2:       return 32'h8000_0000;
         3:       return 32'h0000_0001;
         default: return $urandom();
      endcase
   endfunction

   initial begin
      int run_len;
      int start_count;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: seed extremes, draws right after most reseeds (the first draw
      // after a reseed forces a full regeneration), back-to-back reseeds, and a reseed
      // that lands in the middle of a partly consumed table.
      set_pacing(0);
      send_item(mtg_pkg::OP_RESEED, 32'h0000_0000);
      send_item(mtg_pkg::OP_DRAW,   32'hffff_ffff);
      send_item(mtg_pkg::OP_DRAW,   32'h0000_0000);
      send_item(mtg_pkg::OP_DRAW,   32'hffff_ffff);
      send_item(mtg_pkg::OP_RESEED, 32'hffff_ffff);
      send_draws(3);
      send_item(mtg_pkg::OP_RESEED, 32'h8000_0000);
      send_draws(2);
      send_item(mtg_pkg::OP_RESEED, 32'h0000_0001);
      send_item(mtg_pkg::OP_RESEED, 32'h7fff_ffff);
      send_draws(2);
      send_item(mtg_pkg::OP_RESEED, 32'haaaa_aaaa);
      send_draws(1);
      send_item(mtg_pkg::OP_RESEED, 32'h5555_5555);
      send_draws(2);

      // Random: blocks of reseed + a run of draws. Most runs are short;
      // some pass 624 draws so the table wraps and regenerates mid-stream.
      // Occasionally a second reseed follows right away.
      start_count = reseeds_sent + draws_sent;
      while (reseeds_sent + draws_sent - start_count < RANDOM_ITEMS) begin
         set_pacing(blocks_run % 4);
         send_item(mtg_pkg::OP_RESEED, pick_seed());
         if ($urandom_range(0, 9) == 0) begin
            send_item(mtg_pkg::OP_RESEED, pick_seed());
         end
         if (blocks_run == 1 || blocks_run == 6 || $urandom_range(0, 9) == 0) begin
            run_len = $urandom_range(620, 700);
         end else begin
            run_len = $urandom_range(1, 60);
         end
         send_draws(run_len);
         blocks_run++;
      end
      req_tvalid <= 1'b0;

      // drain: wait for every predicted word, then keep clocking
      // so a stray extra word would still be caught
      while (words_pending != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d reseeds and %0d draws over %0d random blocks in four pacing modes;",
               reseeds_sent, draws_sent, blocks_run);
      $display("%0d words compared, including runs across table regeneration.",
               words_checked);
      if (fail_count == 0 && words_pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/mtg_pkg.sv
sv/mtg_cell.sv
sv/mtg_seed.sv
sv/mersenne_twister_generator_core.sv
tb/sv/mt_stream_checker.sv
tb/sv/testbench.sv
